### design/bnd_pkg.sv
`timescale 1ns / 1ps
package bnd_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int AddrW     = $clog2(MaxWidth);

  localparam int FwW  = 12;
  localparam int FhW  = 13;
  localparam int CfgW = 13;

  localparam logic [1:0] CfgFrameWidth   = 2'd0;
  localparam logic [1:0] CfgFrameHeight  = 2'd1;
  localparam logic [1:0] CfgBayerPattern = 2'd2;

  localparam logic [1:0] ColRed   = 2'd0;
  localparam logic [1:0] ColGreen = 2'd1;
  localparam logic [1:0] ColBlue  = 2'd2;

  // reciprocal of three for sums below 1024
  localparam logic [9:0] RecipThree = 10'd683;

  typedef struct packed {
    logic accept;
    logic shift;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_busy;
  } dp_status_t;

  // filter colour at a site, by pattern and row and column parity
  function automatic logic [1:0] site_colour(logic [1:0] pat, logic y_odd, logic x_odd);
    logic [1:0] col;
    col = ColGreen;
    case ({pat, y_odd, x_odd})
      4'b0000: col = ColRed;
      4'b0011: col = ColBlue;
      4'b0100: col = ColBlue;
      4'b0111: col = ColRed;
      4'b1001: col = ColRed;
      4'b1010: col = ColBlue;
      4'b1101: col = ColBlue;
      4'b1110: col = ColRed;
      default: col = ColGreen;
    endcase
    return col;
  endfunction

  function automatic logic [7:0] nb_average(logic [9:0] sum, logic [2:0] cnt,
                                            logic [7:0] centre);
    logic [19:0] prod;
    logic [7:0]  res;
    prod = sum * RecipThree;
    res  = centre;
    case (cnt)
      3'd1:    res = sum[7:0];
      3'd2:    res = sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = sum[9:2];
      default: res = centre;
    endcase
    return res;
  endfunction

endpackage

### design/bnd_ctrl.sv
`timescale 1ns / 1ps
module bnd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bnd_pkg::dp_status_t status_i,
  output bnd_pkg::ctrl_cmd_t  cmd_o
);
  import bnd_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StEmit
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == StIdle) && in_valid_i;
    cmd_o.shift  = (state_q == StShift);
    cmd_o.load   = (state_q == StEmit) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.accept && !status_i.skip) state_q <= StShift;
        end
        StShift: state_q <= StEmit;
        StEmit: begin
          if (!status_i.out_busy) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### design/bnd_datapath.sv
`timescale 1ns / 1ps
module bnd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  input  logic                action_i,
  input  logic [7:0]          raw_pixel_i,
  input  bnd_pkg::ctrl_cmd_t  cmd_i,
  output bnd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                frame_end_o
);
  import bnd_pkg::*;

  logic [FwW-1:0] fw_q;
  logic [FhW-1:0] fh_q;
  logic [1:0]     pat_q;

  logic [7:0] older_mem [MaxWidth];
  logic [7:0] newer_mem [MaxWidth];
  logic [7:0] old_rd_q, new_rd_q;

  logic [7:0]       win_q [9];
  logic [AddrW-1:0] col_q;
  logic [12:0]      row_q;
  logic [7:0]       pix_q;
  logic [11:0]      ox_q;
  logic [12:0]      oy_q;
  logic             emit_q, last_q;

  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [AddrW-1:0] col_n;
  logic [12:0] row_n;
  logic [13:0] row_inc;

  // clamp the configured frame size
  always_comb begin
    w_eff = fw_q;
    if (fw_q == '0) w_eff = 12'd1;
    else if ({1'b0, fw_q} > 13'(MaxWidth)) w_eff = 12'(MaxWidth);
    h_eff = fh_q;
    if (fh_q == '0) h_eff = 13'd1;
    else if (fh_q > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
  end

  // position of the incoming item after wrap and restart
  always_comb begin
    col_n   = col_q;
    row_inc = {1'b0, row_q};
    if ({1'b0, col_q} >= w_eff) begin
      col_n   = '0;
      row_inc = {1'b0, row_q} + 14'd1;
    end
    row_n = row_inc[12:0];
    if (row_inc > {1'b0, h_eff} + 14'd1) begin
      col_n = '0;
      row_n = '0;
    end
  end

  assign status_o.skip     = action_i && (col_n == '0) && (row_n == '0);
  assign status_o.out_busy = out_valid_o && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 12'd640;
      fh_q  <= 13'd480;
      pat_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFrameWidth:   fw_q  <= cfg_data_i[FwW-1:0];
        CfgFrameHeight:  fh_q  <= cfg_data_i[FhW-1:0];
        CfgBayerPattern: pat_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // row stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      old_rd_q <= older_mem[col_n];
      new_rd_q <= newer_mem[col_n];
    end
    if (cmd_i.shift) begin
      older_mem[col_q] <= new_rd_q;
      newer_mem[col_q] <= pix_q;
    end
  end

  logic [12:0] col_inc;
  logic [13:0] oy_s;
  logic [11:0] ox_s;
  logic        emit_s, last_s;

  always_comb begin
    col_inc = {2'b0, col_q} + 13'd1;
    if (col_q != '0) begin
      ox_s = {1'b0, col_q} - 12'd1;
      oy_s = {1'b0, row_q} - 14'd1;
    end else begin
      ox_s = w_eff - 12'd1;
      oy_s = {1'b0, row_q} - 14'd2;
    end
    emit_s = !oy_s[13] && (oy_s[12:0] < h_eff);
    last_s = emit_s && (ox_s == w_eff - 12'd1) && (oy_s[12:0] == h_eff - 13'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= 1'b0;
      last_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_n;
      row_q <= row_n;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= old_rd_q;
      win_q[5] <= new_rd_q;
      win_q[8] <= pix_q;
      emit_q   <= emit_s;
      last_q   <= last_s;
      if (last_s) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_inc >= {1'b0, w_eff}) begin
        col_q <= '0;
        row_q <= row_q + 13'd1;
      end else begin
        col_q <= col_inc[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) pix_q <= action_i ? 8'd0 : raw_pixel_i;
    if (cmd_i.shift) begin
      ox_q <= ox_s;
      oy_q <= oy_s[12:0];
    end
  end

  // neighbour sums per colour
  logic [9:0] sum_r, sum_g, sum_b;
  logic [2:0] cnt_r, cnt_g, cnt_b;
  logic [1:0] own_col;
  logic [7:0] ch_r, ch_g, ch_b;

  always_comb begin
    logic       row_ok, col_ok;
    logic [1:0] nc;
    sum_r = '0; sum_g = '0; sum_b = '0;
    cnt_r = '0; cnt_g = '0; cnt_b = '0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        row_ok = (dy == 1) || ((dy == 0) && (oy_q != '0)) ||
                 ((dy == 2) && ({1'b0, oy_q} + 14'd1 < {1'b0, h_eff}));
        col_ok = (dx == 1) || ((dx == 0) && (ox_q != '0)) ||
                 ((dx == 2) && ({1'b0, ox_q} + 13'd1 < {1'b0, w_eff}));
        nc = site_colour(pat_q, oy_q[0] ^ (dy != 1), ox_q[0] ^ (dx != 1));
        if (row_ok && col_ok && !((dx == 1) && (dy == 1))) begin
          case (nc)
            ColRed: begin
              sum_r = sum_r + 10'(win_q[dy*3+dx]);
              cnt_r = cnt_r + 3'd1;
            end
            ColGreen: begin
              sum_g = sum_g + 10'(win_q[dy*3+dx]);
              cnt_g = cnt_g + 3'd1;
            end
            default: begin
              sum_b = sum_b + 10'(win_q[dy*3+dx]);
              cnt_b = cnt_b + 3'd1;
            end
          endcase
        end
      end
    end
    own_col = site_colour(pat_q, oy_q[0], ox_q[0]);
    ch_r = (own_col == ColRed)   ? win_q[4] : nb_average(sum_r, cnt_r, win_q[4]);
    ch_g = (own_col == ColGreen) ? win_q[4] : nb_average(sum_g, cnt_g, win_q[4]);
    ch_b = (own_col == ColBlue)  ? win_q[4] : nb_average(sum_b, cnt_b, win_q[4]);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= emit_q;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_o       <= ch_r;
      green_o     <= ch_g;
      blue_o      <= ch_b;
      frame_end_o <= last_q;
    end
  end

endmodule

### design/bayer_neighbour_demosaic.sv
`timescale 1ns / 1ps
// bayer neighbour demosaic: one rgb item per raster position, one frame row and a pixel behind
// each item passes through accept and row store read, window shift, then result into output reg
// a new item is taken only once the idle, shift and emit sequence is back in idle
// the result is registered in the emit state; a waiting result holds the input off
// reset (rst_ni, async low) clears position counters, window, output valid and loads
// default geometry 640 x 480 with gb layout; row stores are not cleared
module bayer_neighbour_demosaic (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  raw_pixel_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        frame_end_o
);
  import bnd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: idle, shift, emit
  bnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // row stores, 3x3 window, position counters, colour interpolation
  bnd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .raw_pixel_i (raw_pixel_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .frame_end_o (frame_end_o)
  );

endmodule

### sim/tb_bayer_neighbour_demosaic.sv
`timescale 1ns / 1ps
module tb_bayer_neighbour_demosaic;
  import bnd_pkg::*;

  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [7:0]  raw_pixel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o, green_o, blue_o;
  logic        frame_end_o;

  bayer_neighbour_demosaic u_top (.*);

  always #10 clk_i = ~clk_i;

  // shadow of the block: registers, row stores, window and raster position
  logic [11:0] sh_width = 12'd640;
  logic [12:0] sh_height = 13'd480;
  logic [1:0]  sh_pattern = 2'd3;
  logic [7:0]  older_row [MaxWidth];
  logic [7:0]  newer_row [MaxWidth];
  logic [7:0]  win [9];
  int          col_pos = 0;
  int          row_pos = 0;

  rgb_pixel_t  pending_pixels[$];
  int          items_sent = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  int          rx_gap_left = 0;
  bit          idle_on = 1'b1;
  bit          failed = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // filter colour of a site: 0 red, 1 green, 2 blue
  function automatic int filter_colour(int x, int y);
    int odd_y, odd_x;
    odd_y = y & 1;
    odd_x = x & 1;
    if (odd_y == odd_x) begin
      case (sh_pattern)
        2'd0: return (odd_x != 0) ? 2 : 0;
        2'd1: return (odd_x != 0) ? 0 : 2;
        default: return 1;
      endcase
    end
    case (sh_pattern)
      2'd2: return (odd_x != 0) ? 0 : 2;
      2'd3: return (odd_x != 0) ? 2 : 0;
      default: return 1;
    endcase
  endfunction

  function automatic logic [7:0] channel_of(int ch, int ox, int oy, int w, int h);
    int sum, cnt, sx, sy;
    sum = 0;
    cnt = 0;
    if (filter_colour(ox, oy) == ch) return win[4];
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        sy = oy + dy;
        sx = ox + dx;
        if (sy >= 0 && sy < h && sx >= 0 && sx < w && !(dx == 0 && dy == 0) &&
            filter_colour(sx, sy) == ch) begin
          sum += win[(dy + 1) * 3 + dx + 1];
          cnt++;
        end
      end
    end
    return (cnt > 0) ? 8'(sum / cnt) : win[4];
  endfunction

  // advance the shadow by one accepted item and queue the pixel it releases
  task automatic demosaic_step(input logic act, input logic [7:0] px);
    int w, h, c, ox, oy;
    bit emit, last;
    rgb_pixel_t res;
    w = (sh_width == 0) ? 1 : ((sh_width > MaxWidth) ? MaxWidth : int'(sh_width));
    h = (sh_height == 0) ? 1 : ((sh_height > MaxHeight) ? MaxHeight : int'(sh_height));
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    // idle pad at the frame origin is dropped
    if (act && col_pos == 0 && row_pos == 0) return;
    c = col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i * 3] = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = older_row[c];
    win[5] = newer_row[c];
    win[8] = act ? 8'd0 : px;
    older_row[c] = newer_row[c];
    newer_row[c] = win[8];
    if (c >= 1) begin
      ox = c - 1;
      oy = row_pos - 1;
    end else begin
      ox = w - 1;
      oy = row_pos - 2;
    end
    emit = ox >= 0 && ox < w && oy >= 0 && oy < h;
    last = emit && ox == w - 1 && oy == h - 1;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (emit) begin
      res.red = channel_of(0, ox, oy, w, h);
      res.green = channel_of(1, ox, oy, w, h);
      res.blue = channel_of(2, ox, oy, w, h);
      res.frame_end = last;
      pending_pixels.push_back(res);
    end
  endtask

  task automatic send_item(input logic act, input logic [7:0] px);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    raw_pixel_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    demosaic_step(act, px);
    items_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drain every queued pixel, then cover the pipeline latency
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 13'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFrameWidth:   sh_width = 12'(val);
      CfgFrameHeight:  sh_height = 13'(val);
      CfgBayerPattern: sh_pattern = 2'(val);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int w, input int h, input int pat);
    settle();
    write_reg(CfgFrameWidth, w);
    write_reg(CfgFrameHeight, h);
    write_reg(CfgBayerPattern, pat);
  endtask

  // pad (or raw, when raw_fill) until the frame closes back to the origin
  task automatic finish_frame(input bit raw_fill);
    while (col_pos != 0 || row_pos != 0)
      send_item(raw_fill ? 1'b0 : 1'b1, 8'($urandom));
  endtask

  // kind: 0 random, 1 all zero, 2 all full scale, 3 chequer of extremes
  task automatic send_frame(input int npix, input int kind, input int pad_pct,
                            input bit raw_fill);
    logic [7:0] px;
    for (int i = 0; i < npix; i++) begin
      case (kind)
        1: px = 8'h00;
        2: px = 8'hff;
        3: px = i[0] ? 8'hff : 8'h00;
        default: px = 8'($urandom);
      endcase
      send_item($urandom_range(99) < pad_pct, px);
    end
    finish_frame(raw_fill);
  endtask

  task automatic test_directed();
    // idle pads at the origin give nothing
    send_item(1'b1, 8'hff);
    send_item(1'b1, 8'h00);
    for (int p = 0; p < 4; p++) begin
      set_geometry(3, 3, p);
      send_frame(9, (p == 0) ? 3 : 0, 0, 1'b0);
    end
    set_geometry(2, 2, 0);
    send_frame(4, 2, 0, 1'b0);
    set_geometry(0, 0, 1);   // zero clamps to one by one
    send_frame(1, 2, 0, 1'b0);
    // pads inside the frame count as zero, raw pixels fill the flush
    set_geometry(4, 3, 2);
    send_frame(12, 2, 40, 1'b1);
  endtask

  task automatic test_extremes();
    // width above the maximum, then a narrow width wraps the long row
    set_geometry(4095, 1, 0);
    for (int i = 0; i < 12; i++) send_item(1'b0, 8'($urandom));
    settle();
    write_reg(CfgFrameWidth, 4);
    finish_frame(1'b0);
    // height above the maximum, then a short height restarts the frame
    set_geometry(2, 8191, 3);
    for (int i = 0; i < 20; i++) send_item(1'b0, 8'($urandom));
    settle();
    write_reg(CfgFrameHeight, 2);
    finish_frame(1'b0);
  endtask

  task automatic test_reconfig_mid_frame();
    set_geometry(6, 6, 1);
    send_frame(0, 0, 0, 1'b0);
    for (int i = 0; i < 20; i++) send_item(1'b0, 8'($urandom));
    settle();
    write_reg(CfgFrameWidth, 2);    // column now beyond the width
    for (int i = 0; i < 5; i++) send_item(1'b0, 8'($urandom));
    settle();
    write_reg(CfgFrameHeight, 1);   // row now beyond the height, frame restarts
    finish_frame(1'b0);
    send_frame(3, 0, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_geometry(8, 4, 2);
    idle_on = 1'b0;
    hold_left = 300;
    send_frame(32, 0, 0, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int stop_at, w, h;
    stop_at = items_sent + 1000;
    while (items_sent < stop_at) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(10, 1);
      h = $urandom_range(7, 1);
      set_geometry(w, h, $urandom_range(3));
      idle_on = $urandom_range(3) != 0;
      repeat ($urandom_range(9) == 0 ? 2 : 0) send_item(1'b1, 8'($urandom));
      // a few frames are cut short and closed out by the flush
      send_frame(($urandom_range(9) == 0) ? $urandom_range(w * h) : w * h, 0,
                 ($urandom_range(4) == 0) ? 15 : 0, $urandom_range(3) == 0);
    end
    idle_on = 1'b1;
  endtask

  // receiver: random hold-offs, or a long forced stretch
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (rx_gap_left > 0) begin
        out_stall_i <= 1'b1;
        rx_gap_left--;
      end else begin
        out_stall_i <= 1'b0;
        rx_gap_left = idle_on ? pick_gap() : 0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rgb_pixel_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected item: red %0d green %0d blue %0d", red_o, green_o, blue_o);
        failed = 1'b1;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (red_o !== exp_px.red) begin
          $error("red expected %0d actual %0d", exp_px.red, red_o);
          failed = 1'b1;
        end
        if (green_o !== exp_px.green) begin
          $error("green expected %0d actual %0d", exp_px.green, green_o);
          failed = 1'b1;
        end
        if (blue_o !== exp_px.blue) begin
          $error("blue expected %0d actual %0d", exp_px.blue, blue_o);
          failed = 1'b1;
        end
        if (frame_end_o !== exp_px.frame_end) begin
          $error("frame_end expected %0d actual %0d", exp_px.frame_end, frame_end_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL bayer_neighbour_demosaic");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_extremes();
    test_reconfig_mid_frame();
    test_backpressure();
    test_random();
    settle();
    repeat (20) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d expected items never arrived", pending_pixels.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("PASS bayer_neighbour_demosaic");
    end else begin
      $display("FAIL bayer_neighbour_demosaic");
    end
    $finish;
  end

endmodule

### files.f
design/bnd_pkg.sv
design/bnd_ctrl.sv
design/bnd_datapath.sv
design/bayer_neighbour_demosaic.sv
sim/tb_bayer_neighbour_demosaic.sv
